// ===== design/rgba8_to_texel_format_packer_defines.svh =====
// Assertion helpers shared by the packer modules.
// Every module that asserts has ports named aclk and aresetn.
`ifndef RGBA8_TO_TEXEL_FORMAT_PACKER_DEFINES_SVH
`define RGBA8_TO_TEXEL_FORMAT_PACKER_DEFINES_SVH

// Consequent checked in the same cycle as the antecedent.
`define TXP_ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("packer check failed");

// Consequent checked in the cycle after the antecedent.
`define TXP_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("packer check failed");

`endif

// ===== design/txp_pkg.sv =====
package txp_pkg;

    localparam logic [3:0] FMT_RGB5A1   = 4'd0;
    localparam logic [3:0] FMT_RGBA8888 = 4'd1;
    localparam logic [3:0] FMT_CI4      = 4'd2;
    localparam logic [3:0] FMT_CI8      = 4'd3;
    localparam logic [3:0] FMT_IA4      = 4'd4;
    localparam logic [3:0] FMT_IA8      = 4'd5;
    localparam logic [3:0] FMT_IA88     = 4'd6;
    localparam logic [3:0] FMT_I4       = 4'd7;
    localparam logic [3:0] FMT_I8       = 4'd8;

    // ci4 only looks at the first entries of the palette
    localparam int CI4_LEN = 16;

    // One item moving down the cell row, with the search results so far.
    typedef struct packed {
        logic        valid;
        logic        load;
        logic [7:0]  pal_index;
        logic [3:0]  fmt;
        logic [31:0] px0;
        logic [31:0] px1;
        logic        found0;
        logic [7:0]  idx0;
        logic        found1;
        logic [3:0]  idx1;
    } item_t;

endpackage

// ===== design/rgba8_to_texel_format_packer.sv =====
// RGBA8 to texel format packer.
// Input channel s_*: one item per transfer, either a pixel pair to convert
// (s_action low) or a palette entry load (s_action high, entry bytes on
// s_red0..s_alpha0, slot on s_pal_index). Result channel m_*: one packed
// texel and a palette hit flag per convert item in a known format; loads
// and unknown formats produce no result. cfg_*: writes the 4-bit format;
// cfg_ready is always high.
// Every item walks a row of PALETTE_DEPTH cells, one cell per cycle while
// the row advances; each cell holds one palette entry, compares it against
// the item and applies loads addressed to it, so loads and searches stay in
// order. The result is registered in txp_out after the last cell.
// Throughput: one item per cycle while the receiver does not stall the row.
// Reset clears the format to RGB5A1, every palette entry to zero and all
// items in flight. When the receiver stalls with a result waiting, the
// whole row holds and s_ready drops until that result transfers.
`include "rgba8_to_texel_format_packer_defines.svh"

module rgba8_to_texel_format_packer #(
    parameter int PALETTE_DEPTH = 256
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [3:0]  cfg_data,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_action,
    input  logic [7:0]  s_pal_index,
    input  logic [7:0]  s_red0,
    input  logic [7:0]  s_green0,
    input  logic [7:0]  s_blue0,
    input  logic [7:0]  s_alpha0,
    input  logic [7:0]  s_red1,
    input  logic [7:0]  s_green1,
    input  logic [7:0]  s_blue1,
    input  logic [7:0]  s_alpha1,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [31:0] m_texel,
    output logic        m_palette_hit
);

    logic [3:0]     format_reg;
    logic           adv;
    txp_pkg::item_t chain [PALETTE_DEPTH+1];

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            format_reg <= txp_pkg::FMT_RGB5A1;
        end else if (cfg_valid) begin
            format_reg <= cfg_data;
        end
    end

    assign s_ready = adv;

    always_comb begin
        chain[0].valid     = s_valid;
        chain[0].load      = s_action;
        chain[0].pal_index = s_pal_index;
        chain[0].fmt       = format_reg;
        chain[0].px0       = {s_red0, s_green0, s_blue0, s_alpha0};
        chain[0].px1       = {s_red1, s_green1, s_blue1, s_alpha1};
        chain[0].found0    = 1'b0;
        chain[0].idx0      = 8'd0;
        chain[0].found1    = 1'b0;
        chain[0].idx1      = 4'd0;
    end

    for (genvar gi = 0; gi < PALETTE_DEPTH; gi++) begin : g_cell
        txp_cell #(
            .IDX(gi)
        ) u_cell (
            .aclk    (aclk),
            .aresetn (aresetn),
            .adv     (adv),
            .item_in (chain[gi]),
            .item_out(chain[gi+1])
        );
    end

    txp_out u_out (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .item_in      (chain[PALETTE_DEPTH]),
        .m_ready      (m_ready),
        .adv          (adv),
        .m_valid      (m_valid),
        .m_texel      (m_texel),
        .m_palette_hit(m_palette_hit)
    );

    `TXP_ASSERT_SAME(a_stall_blocks_input, m_valid && !m_ready, !s_ready)

endmodule

// ===== design/txp_cell.sv =====
`include "rgba8_to_texel_format_packer_defines.svh"

module txp_cell #(
    parameter int IDX = 0
) (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            adv,
    input  txp_pkg::item_t  item_in,
    output txp_pkg::item_t  item_out
);

    localparam logic [7:0] ID     = 8'(IDX);
    localparam bit         IN_CI4 = (IDX < txp_pkg::CI4_LEN);

    logic [31:0]    entry_reg;
    txp_pkg::item_t item_reg;
    txp_pkg::item_t item_next;
    logic           srch;
    logic           hit0;
    logic           hit1;
    logic           wr;

    assign srch = item_in.valid && !item_in.load;
    assign wr   = item_in.valid && item_in.load && (item_in.pal_index == ID);

    always_comb begin
        hit0 = srch && !item_in.found0 && (entry_reg == item_in.px0) &&
               ((item_in.fmt == txp_pkg::FMT_CI8) ||
                ((item_in.fmt == txp_pkg::FMT_CI4) && IN_CI4));
        hit1 = srch && !item_in.found1 && (entry_reg == item_in.px1) &&
               (item_in.fmt == txp_pkg::FMT_CI4) && IN_CI4;
        item_next = item_in;
        if (hit0) begin
            item_next.found0 = 1'b1;
            item_next.idx0   = ID;
        end
        if (hit1) begin
            item_next.found1 = 1'b1;
            item_next.idx1   = ID[3:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            entry_reg <= 32'd0;
        end else if (adv && wr) begin
            entry_reg <= item_in.px0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            item_reg.valid <= 1'b0;
        end else if (adv) begin
            item_reg <= item_next;
        end
    end

    assign item_out = item_reg;

    `TXP_ASSERT_SAME(a_idx_in_range, item_reg.valid && item_reg.found0, item_reg.idx0 <= ID)
    `TXP_ASSERT_NEXT(a_entry_written, adv && wr, entry_reg == $past(item_in.px0))

endmodule

// ===== design/txp_out.sv =====
`include "rgba8_to_texel_format_packer_defines.svh"

module txp_out (
    input  logic            aclk,
    input  logic            aresetn,
    input  txp_pkg::item_t  item_in,
    input  logic            m_ready,
    output logic            adv,
    output logic            m_valid,
    output logic [31:0]     m_texel,
    output logic            m_palette_hit
);

    // reciprocals, exact over the operand ranges used here
    localparam logic [26:0] Mul255 = 27'd8225;
    localparam logic [19:0] Mul3   = 20'd683;
    localparam logic [20:0] Mul51  = 21'd1286;
    localparam logic [25:0] Mul765 = 26'd5483;
    localparam logic [15:0] Mul17  = 16'd241;

    function automatic logic [4:0] chan5(input logic [7:0] x);
        logic [12:0] n;
        logic [26:0] p;
        n = 13'(x) * 13'd31 + 13'd127;
        p = 27'(n) * Mul255;
        return 5'(p >> 21);
    endfunction

    function automatic logic [7:0] int8(input logic [9:0] s);
        logic [19:0] p;
        p = 20'(s) * Mul3;
        return 8'(p >> 11);
    endfunction

    function automatic logic [3:0] int4(input logic [9:0] s);
        logic [9:0]  n;
        logic [20:0] p;
        n = s + 10'd8;
        p = 21'(n) * Mul51;
        return 4'(p >> 16);
    endfunction

    function automatic logic [2:0] int3(input logic [9:0] s);
        logic [12:0] n;
        logic [25:0] p;
        n = 13'(s) * 13'd7 + 13'd127;
        p = 26'(n) * Mul765;
        return 3'(p >> 22);
    endfunction

    function automatic logic [3:0] alpha4(input logic [7:0] a);
        logic [15:0] p;
        p = 16'(a) * Mul17;
        return 4'(p >> 12);
    endfunction

    logic [7:0]  r0, g0, b0, a0, r1, g1, b1, a1;
    logic [9:0]  sum0, sum1;
    logic [31:0] texel_c;
    logic        hit_c;
    logic        known;
    logic        produce;
    logic        m_valid_reg, m_valid_next;
    logic [31:0] m_texel_reg;
    logic        m_hit_reg;

    assign {r0, g0, b0, a0} = item_in.px0;
    assign {r1, g1, b1, a1} = item_in.px1;
    assign sum0 = 10'(r0) + 10'(g0) + 10'(b0);
    assign sum1 = 10'(r1) + 10'(g1) + 10'(b1);

    always_comb begin
        known   = 1'b1;
        hit_c   = 1'b1;
        texel_c = 32'd0;
        unique case (item_in.fmt)
            txp_pkg::FMT_RGB5A1: texel_c = {16'd0, chan5(r0), chan5(g0), chan5(b0), a0[7]};
            txp_pkg::FMT_RGBA8888: texel_c = item_in.px0;
            txp_pkg::FMT_CI4: begin
                texel_c = {24'd0, item_in.idx0[3:0], item_in.idx1};
                hit_c   = item_in.found0 && item_in.found1;
            end
            txp_pkg::FMT_CI8: begin
                texel_c = {24'd0, item_in.idx0};
                hit_c   = item_in.found0;
            end
            txp_pkg::FMT_IA4:  texel_c = {24'd0, int3(sum0), a0[7], int3(sum1), a1[7]};
            txp_pkg::FMT_IA8:  texel_c = {24'd0, int4(sum0), alpha4(a0)};
            txp_pkg::FMT_IA88: texel_c = {16'd0, int8(sum0), a0};
            txp_pkg::FMT_I4:   texel_c = {24'd0, int4(sum0), int4(sum1)};
            txp_pkg::FMT_I8:   texel_c = {24'd0, int8(sum0)};
            default:           known   = 1'b0;
        endcase
    end

    // drop loads and unknown formats at the end of the row
    assign produce      = item_in.valid && !item_in.load && known;
    assign adv          = !m_valid_reg || m_ready;
    assign m_valid_next = adv ? produce : m_valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv && produce) begin
            m_texel_reg <= texel_c;
            m_hit_reg   <= hit_c;
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_texel       = m_texel_reg;
    assign m_palette_hit = m_hit_reg;

    `TXP_ASSERT_SAME(a_rise_from_convert, $rose(m_valid_reg), $past(adv && produce))

endmodule
